### rtl/lpp_pkg.sv
// Package for the Lissajous particle plotter: payload types, constants and the sine table.
package lpp_pkg;

    localparam int MAX_PARTICLES   = 1024;
    localparam int SINE_TABLE_BITS = 10;
    localparam int QUARTER         = 1 << (SINE_TABLE_BITS - 2);
    localparam int QBITS           = SINE_TABLE_BITS - 2;

    localparam logic [2:0] REG_WINDOW_OFFSET = 3'd0;
    localparam logic [2:0] REG_WINDOW_WIDTH  = 3'd1;
    localparam logic [2:0] REG_PANEL_HEIGHT  = 3'd2;
    localparam logic [2:0] REG_PARTICLE_CNT  = 3'd3;
    localparam logic [2:0] REG_FRAME_STEP    = 3'd4;
    localparam logic [2:0] REG_X_STEP        = 3'd5;
    localparam logic [2:0] REG_Y_STEP        = 3'd6;

    typedef struct packed {
        logic [9:0] particle_index;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        logic        pixel_visible;
        logic [10:0] pixel_x;
        logic [9:0]  pixel_y;
        logic [7:0]  grey_level;
        logic        frame_done;
    } t_out_item;

    typedef logic [QUARTER-1:0][14:0] t_qtab;

    function automatic logic [63:0] quarter_sine(input logic [63:0] q);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] s;
        t  = (q << 16) >> QBITS;
        t2 = (t * t) >> 16;
        a  = (64'd4926 * t2) >> 16;
        b  = (t2 * (64'd42334 - a)) >> 16;
        s  = (t * (64'd102944 - b)) >> 16;
        return (s * 64'd32767 + 64'd32768) >> 16;
    endfunction

    function automatic t_qtab build_qtab();
        t_qtab tab;
        for (int k = 0; k < QUARTER; k++) begin
            tab[k] = 15'(quarter_sine(64'(k)));
        end
        return tab;
    endfunction

    localparam t_qtab       QTAB    = build_qtab();
    localparam logic [14:0] QS_PEAK = 15'(quarter_sine(64'(QUARTER)));

    // Q1.15 sine of a 24-bit turn fraction, built from the quarter-wave table.
    function automatic logic signed [16:0] sine_of(input logic [23:0] ang);
        logic [SINE_TABLE_BITS-1:0] idx;
        logic [QBITS-1:0]           q;
        logic [QBITS-1:0]           qr;
        logic [14:0]                v;
        idx = ang[23 -: SINE_TABLE_BITS];
        q   = idx[QBITS-1:0];
        qr  = QBITS'(0) - q;
        if (!idx[QBITS]) begin
            v = QTAB[q];
        end else if (q == '0) begin
            v = QS_PEAK;
        end else begin
            v = QTAB[qr];
        end
        if (idx[QBITS+1]) begin
            return -$signed({2'b00, v});
        end else begin
            return $signed({2'b00, v});
        end
    endfunction

endpackage

### rtl/lissajous_particle_plotter.sv
// Lissajous particle plotter: sequencer around one shared multiplier and a restoring divider.
//
// Each accepted particle index runs through the multiply, divide and done states until its result is
// loaded into the output register, waiting in the done state while a previous result still waits there,
// and the next index is taken in the cycle after that.
// The steps are set by the single multiplier, which forms the two angles, the two
// amplitudes and the two scaled sine values one after another, and by the 8-step
// restoring divider that produces the grey level. The result register holds a finished
// transaction while the block already accepts the next index. Configuration writes are
// accepted in every cycle and must only be issued while the block is idle.
module lissajous_particle_plotter
    import lpp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MULX,
        ST_MULY,
        ST_MULAX,
        ST_MULAY,
        ST_SCX,
        ST_SCY,
        ST_DIVI,
        ST_DIV,
        ST_DONE
    } t_state;

    t_state r_state;

    logic [9:0]  r_offset;
    logic [10:0] r_width;
    logic [10:0] r_height;
    logic [10:0] r_count;
    logic [23:0] r_frame_step;
    logic [23:0] r_x_step;
    logic [23:0] r_y_step;
    logic [23:0] r_phase;

    logic [9:0]         r_index;
    logic               r_frame_end;
    logic [23:0]        r_angx;
    logic [23:0]        r_angy;
    logic [18:0]        r_ax;
    logic [17:0]        r_ay;
    logic signed [16:0] r_sin;
    logic signed [35:0] r_prod;
    logic signed [21:0] r_x;
    logic signed [21:0] r_y;
    logic [17:0]        r_rem;
    logic [17:0]        r_dvs;
    logic [7:0]         r_quo;
    logic [2:0]         r_cnt;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [10:0]        w_n;
    logic [10:0]        w_m;
    logic               w_in_range;
    logic signed [24:0] w_mul_a;
    logic signed [18:0] w_mul_b;
    logic signed [43:0] w_mul_p;
    logic signed [16:0] w_sine;
    logic signed [21:0] w_cx;
    logic signed [21:0] w_cy;
    logic signed [21:0] w_d;
    logic [10:0]        w_diff;
    logic [18:0]        w_dividend;
    logic               w_vis;
    logic signed [21:0] w_xlo;
    logic signed [21:0] w_xhi;
    logic signed [21:0] w_yhi;

    assign w_n = (r_count > 11'(MAX_PARTICLES)) ? 11'(MAX_PARTICLES) : r_count;
    assign w_m = (r_height < r_width) ? r_height : r_width;
    assign w_in_range = {1'b0, r_index} < w_n;

    always_comb begin
        case (r_state)
            ST_MULX: begin
                w_mul_a = $signed({1'b0, r_x_step});
                w_mul_b = $signed({9'd0, r_index});
            end
            ST_MULY: begin
                w_mul_a = $signed({1'b0, r_y_step});
                w_mul_b = $signed({9'd0, r_index});
            end
            ST_MULAX: begin
                w_mul_a = $signed({14'd0, w_m});
                w_mul_b = 19'sd3482;
            end
            ST_MULAY: begin
                w_mul_a = $signed({14'd0, w_m});
                w_mul_b = 19'sd1229;
            end
            ST_SCX: begin
                w_mul_a = $signed({6'd0, r_ax});
                w_mul_b = 19'(r_sin);
            end
            ST_SCY: begin
                w_mul_a = $signed({7'd0, r_ay});
                w_mul_b = 19'(r_sin);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;
    assign w_sine  = sine_of((r_state == ST_MULAY) ? r_angx : r_angy);

    assign w_cx = $signed({4'd0, r_offset, 8'd0}) + $signed({4'd0, r_width, 7'd0});
    assign w_cy = $signed({4'd0, r_height, 7'd0});
    assign w_d  = $signed({r_prod[35], r_prod[35:15]});

    assign w_diff     = w_n - {1'b0, r_index};
    assign w_dividend = {w_diff, 8'd0} - {8'd0, w_diff};

    assign w_xlo = $signed({4'd0, r_offset, 8'd0});
    assign w_xhi = $signed({2'd0, {1'b0, r_offset} + {1'b0, r_width}, 8'd0});
    assign w_yhi = $signed({3'd0, r_height, 8'd0});
    assign w_vis = w_in_range && (r_x >= w_xlo) && (r_x < w_xhi) &&
                   (r_y >= 22'sd0) && (r_y < w_yhi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_offset     <= 10'd0;
            r_width      <= 11'd64;
            r_height     <= 11'd64;
            r_count      <= 11'd900;
            r_frame_step <= 24'd240318;
            r_x_step     <= 24'd12016;
            r_y_step     <= 24'd96127;
            r_phase      <= 24'd0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_WINDOW_OFFSET: r_offset     <= i_cfg_data[9:0];
                    REG_WINDOW_WIDTH:  r_width      <= i_cfg_data[10:0];
                    REG_PANEL_HEIGHT:  r_height     <= i_cfg_data[10:0];
                    REG_PARTICLE_CNT:  r_count      <= i_cfg_data[10:0];
                    REG_FRAME_STEP:    r_frame_step <= i_cfg_data;
                    REG_X_STEP:        r_x_step     <= i_cfg_data;
                    REG_Y_STEP:        r_y_step     <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_out_valid && i_out_ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_index     <= i_in_data.particle_index;
                        r_frame_end <= i_in_data.frame_end;
                        r_state     <= ST_MULX;
                    end
                end
                ST_MULX: begin
                    r_prod  <= w_mul_p[35:0];
                    r_state <= ST_MULY;
                end
                ST_MULY: begin
                    r_angx  <= r_phase + r_prod[23:0];
                    r_prod  <= w_mul_p[35:0];
                    r_state <= ST_MULAX;
                end
                ST_MULAX: begin
                    r_angy  <= r_phase + r_prod[23:0] + 24'h400000;
                    r_prod  <= w_mul_p[35:0];
                    r_state <= ST_MULAY;
                end
                ST_MULAY: begin
                    r_ax    <= r_prod[22:4];
                    r_sin   <= w_sine;
                    r_prod  <= w_mul_p[35:0];
                    r_state <= ST_SCX;
                end
                ST_SCX: begin
                    r_ay    <= r_prod[21:4];
                    r_sin   <= w_sine;
                    r_prod  <= w_mul_p[35:0];
                    r_state <= ST_SCY;
                end
                ST_SCY: begin
                    r_x     <= w_cx - w_d;
                    r_prod  <= w_mul_p[35:0];
                    r_state <= ST_DIVI;
                end
                ST_DIVI: begin
                    r_y     <= w_cy - w_d;
                    r_rem   <= w_dividend[17:0];
                    r_dvs   <= {w_n, 7'd0};
                    r_quo   <= 8'd0;
                    r_cnt   <= 3'd0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (r_rem >= r_dvs) begin
                        r_rem <= r_rem - r_dvs;
                        r_quo <= {r_quo[6:0], 1'b1};
                    end else begin
                        r_quo <= {r_quo[6:0], 1'b0};
                    end
                    r_dvs <= r_dvs >> 1;
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd7) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid         <= 1'b1;
                        r_out.pixel_visible <= w_vis;
                        r_out.pixel_x       <= w_vis ? r_x[18:8] : 11'd0;
                        r_out.pixel_y       <= w_vis ? r_y[17:8] : 10'd0;
                        r_out.grey_level    <= w_in_range ? r_quo : 8'd0;
                        r_out.frame_done    <= r_frame_end;
                        if (r_frame_end) begin
                            r_phase <= r_phase + r_frame_step;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule
